### src/opaque_bbox_classifier_assert.svh
// Assertion macros shared by the opaque bounding box classifier modules
`ifndef OPAQUE_BBOX_CLASSIFIER_ASSERT_SVH
`define OPAQUE_BBOX_CLASSIFIER_ASSERT_SVH

// same-cycle implication, held off during reset
`define OBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define OBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/obc_pkg.sv
// Types and constants of the opaque bounding box classifier
`timescale 1ns / 1ps
package obc_pkg;

  localparam int CoordW  = 8;
  localparam int WidthW  = 9;
  localparam int CountW  = 17;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 9;
  localparam int OutDataW = 40;

  localparam logic [WidthW-1:0] CoordLimit = 9'd256;

  typedef enum logic [CfgAddrW-1:0] {
    REG_IMAGE_WIDTH       = 2'd0,
    REG_TRANSPARENT_INDEX = 2'd1
  } cfg_reg_t;

  // final tracker state of one image
  typedef struct packed {
    logic              seen;
    logic              ovf;
    logic [CoordW-1:0] lc;
    logic [CoordW-1:0] lr;
    logic [CoordW-1:0] gc;
    logic [CoordW-1:0] gr;
    logic [CountW-1:0] count;
  } snap_t;

  // one result item
  typedef struct packed {
    logic              any_opaque;
    logic [CoordW-1:0] box_x;
    logic [CoordW-1:0] box_y;
    logic [WidthW-1:0] box_w;
    logic [WidthW-1:0] box_h;
    logic              is_slab;
    logic              too_large;
  } result_t;

endpackage

### src/obc_tracker.sv
// Per-pixel column/row counters, opaque extent tracking and end-of-image snapshot
`timescale 1ns / 1ps
module obc_tracker #(
  parameter int MAX_DIM = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pix_valid,
  output logic                       pix_ready,
  input  logic [obc_pkg::CoordW-1:0] pixel,
  input  logic                       last,
  input  logic [obc_pkg::WidthW-1:0] image_width,
  input  logic [obc_pkg::CoordW-1:0] transparent_index,
  output logic                       snap_valid,
  input  logic                       snap_ready,
  output obc_pkg::snap_t             snap
);
  import obc_pkg::*;

  logic [CoordW-1:0] col_r, col_nxt;
  logic [WidthW-1:0] row_r, row_nxt;
  logic [CoordW-1:0] lc_r, lc_nxt, lr_r, lr_nxt, gc_r, gc_nxt, gr_r, gr_nxt;
  logic              seen_r, seen_nxt, ovf_r, ovf_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              snap_v_r, snap_v_nxt;
  snap_t             snap_r, snap_upd;

  logic              acc, hit, wrap, ovf_now;
  logic [WidthW-1:0] w_eff, col_inc;
  logic [CoordW-1:0] row_lo;

  assign pix_ready  = !snap_v_r || snap_ready;
  assign acc        = pix_valid && pix_ready;
  assign row_lo     = row_r[CoordW-1:0];
  assign hit        = acc && (row_r < CoordLimit) && (pixel != transparent_index);
  assign col_inc    = {1'b0, col_r} + 9'd1;
  assign wrap       = col_inc >= w_eff;
  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

  always_comb begin
    if (image_width == '0) begin
      w_eff = 9'd1;
    end else if (image_width > CoordLimit) begin
      w_eff = CoordLimit;
    end else begin
      w_eff = image_width;
    end
  end

  assign ovf_now = (image_width > CoordLimit) || (32'(image_width) > MAX_DIM) ||
                   (row_r >= CoordLimit) || (32'(row_r) >= MAX_DIM);

  // state after this pixel
  always_comb begin
    snap_upd.seen  = seen_r || hit;
    snap_upd.ovf   = ovf_r || ovf_now;
    snap_upd.lc    = (hit && col_r < lc_r) ? col_r : lc_r;
    snap_upd.gc    = (hit && col_r > gc_r) ? col_r : gc_r;
    snap_upd.lr    = (hit && row_lo < lr_r) ? row_lo : lr_r;
    snap_upd.gr    = (hit && row_lo > gr_r) ? row_lo : gr_r;
    snap_upd.count = hit ? count_r + 17'd1 : count_r;
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    lc_nxt    = lc_r;
    lr_nxt    = lr_r;
    gc_nxt    = gc_r;
    gr_nxt    = gr_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    count_nxt = count_r;
    if (acc) begin
      if (last) begin
        col_nxt   = '0;
        row_nxt   = '0;
        lc_nxt    = '1;
        lr_nxt    = '1;
        gc_nxt    = '0;
        gr_nxt    = '0;
        seen_nxt  = 1'b0;
        ovf_nxt   = 1'b0;
        count_nxt = '0;
      end else begin
        if (wrap) begin
          col_nxt = '0;
          row_nxt = (row_r < CoordLimit) ? row_r + 9'd1 : CoordLimit;
        end else begin
          col_nxt = col_inc[CoordW-1:0];
        end
        lc_nxt    = snap_upd.lc;
        lr_nxt    = snap_upd.lr;
        gc_nxt    = snap_upd.gc;
        gr_nxt    = snap_upd.gr;
        seen_nxt  = snap_upd.seen;
        ovf_nxt   = snap_upd.ovf;
        count_nxt = snap_upd.count;
      end
    end
  end

  always_comb begin
    snap_v_nxt = snap_v_r;
    if (acc && last) begin
      snap_v_nxt = 1'b1;
    end else if (snap_ready) begin
      snap_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      lc_r     <= '1;
      lr_r     <= '1;
      gc_r     <= '0;
      gr_r     <= '0;
      seen_r   <= 1'b0;
      ovf_r    <= 1'b0;
      count_r  <= '0;
      snap_v_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      lc_r     <= lc_nxt;
      lr_r     <= lr_nxt;
      gc_r     <= gc_nxt;
      gr_r     <= gr_nxt;
      seen_r   <= seen_nxt;
      ovf_r    <= ovf_nxt;
      count_r  <= count_nxt;
      snap_v_r <= snap_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && last) begin
      snap_r <= snap_upd;
    end
  end

`include "opaque_bbox_classifier_assert.svh"

  `OBC_ASSERT_NEXT(a_snap_after_last, acc && last, snap_v_r, "no snapshot after last pixel")
  `OBC_ASSERT_NEXT(a_clear_after_last, acc && last,
                   col_r == '0 && row_r == '0 && !seen_r && count_r == '0,
                   "state not cleared after last pixel")
  `OBC_ASSERT_NEXT(a_seen_on_hit, hit && !last, seen_r && count_r != '0,
                   "opaque pixel not recorded")
  `OBC_ASSERT_NOW(a_row_sat, 1'b1, row_r <= CoordLimit, "row counter past saturation")

endmodule

### src/obc_box.sv
// Box size, slab test and result register
`timescale 1ns / 1ps
module obc_box (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         snap_valid,
  output logic                         snap_ready,
  input  obc_pkg::snap_t               snap,
  output logic                         res_valid,
  input  logic                         res_ready,
  output obc_pkg::result_t             res
);
  import obc_pkg::*;

  logic                out_v_r, out_v_nxt;
  result_t             res_r, res_nxt;
  logic                take;
  logic [WidthW-1:0]   bw, bh;
  logic [2*WidthW-1:0] area;

  assign snap_ready = !out_v_r || res_ready;
  assign take       = snap_valid && snap_ready;
  assign res_valid  = out_v_r;
  assign res        = res_r;

  always_comb begin
    bw   = snap.seen ? ({1'b0, snap.gc} - {1'b0, snap.lc} + 9'd1) : '0;
    bh   = snap.seen ? ({1'b0, snap.gr} - {1'b0, snap.lr} + 9'd1) : '0;
    area = bw * bh;
    res_nxt.any_opaque = snap.seen;
    res_nxt.box_x      = snap.seen ? snap.lc : '0;
    res_nxt.box_y      = snap.seen ? snap.lr : '0;
    res_nxt.box_w      = bw;
    res_nxt.box_h      = bh;
    res_nxt.is_slab    = snap.seen && ({1'b0, snap.count} == area);
    res_nxt.too_large  = snap.ovf;
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (take) begin
      out_v_nxt = 1'b1;
    end else if (res_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

`include "opaque_bbox_classifier_assert.svh"

  `OBC_ASSERT_NOW(a_slab_needs_opaque, out_v_r && res_r.is_slab, res_r.any_opaque,
                  "slab without opaque pixel")
  `OBC_ASSERT_NOW(a_empty_box_zero, out_v_r && !res_r.any_opaque,
                  res_r.box_w == '0 && res_r.box_h == '0 && res_r.box_x == '0,
                  "empty image with nonzero box")
  `OBC_ASSERT_NEXT(a_take_loads, take, out_v_r, "snapshot taken but no result")

endmodule

### src/opaque_bbox_classifier.sv
// Top level of the opaque pixel bounding box classifier
// Usage:
//   in_*  : one palette-index pixel per item in raster order (in_tdata),
//           in_tlast marks the final pixel of an image.
//   out_* : one result item per image: bounding box of the opaque pixels,
//           too-large flag (out_tdata) and slab/billboard class (out_tuser).
//   cfg_* : register writes; index 0 image width, 1 transparent index.
//           Write only while no image is in flight; the block does not check.
// Throughput is one pixel per cycle while in_tready is high; counters and
// min/max compares update in the cycle a pixel is accepted. The last pixel
// moves the image state into the snapshot register; the box width/height
// multiply and compare then load the result register, which sets out_tvalid.
// When the receiver stalls, the result holds and the next image keeps
// streaming; in_tready drops only once a second finished image waits behind
// the held result. Reset clears the counters, the extents and both valid
// flags, and sets the image width to 256 and the transparent index to 0.
`timescale 1ns / 1ps
module opaque_bbox_classifier #(
  parameter int MAX_DIM = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,  // [7:0] pixel_index
  input  logic                         in_tlast,  // last_pixel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [0] any_opaque, [8:1] box_x, [16:9] box_y, [25:17] box_w, [34:26] box_h,
  // [35] too_large, [39:36] zero
  output logic [obc_pkg::OutDataW-1:0] out_tdata,
  output logic                         out_tuser, // is_slab
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [obc_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [obc_pkg::CfgDataW-1:0] cfg_data
);
  import obc_pkg::*;

  logic [WidthW-1:0] width_r;
  logic [CoordW-1:0] transp_r;
  logic              snap_valid, snap_ready;
  snap_t             snap;
  result_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CoordLimit;
      transp_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:       width_r  <= cfg_data;
        REG_TRANSPARENT_INDEX: transp_r <= cfg_data[CoordW-1:0];
        default: ;
      endcase
    end
  end

  obc_tracker #(
    .MAX_DIM(MAX_DIM)
  ) u_tracker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pix_valid        (in_tvalid),
    .pix_ready        (in_tready),
    .pixel            (in_tdata),
    .last             (in_tlast),
    .image_width      (width_r),
    .transparent_index(transp_r),
    .snap_valid       (snap_valid),
    .snap_ready       (snap_ready),
    .snap             (snap)
  );

  obc_box u_box (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .snap      (snap),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {4'b0000, res.too_large, res.box_h, res.box_w,
                      res.box_y, res.box_x, res.any_opaque};
  assign out_tuser = res.is_slab;

endmodule

### tb/tb.sv
// Self-checking bench for the opaque pixel bounding box classifier: directed and random sprite images
`timescale 1ns / 1ps
module tb;
  import obc_pkg::*;

  localparam int MaxDim       = 256;
  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 6;
  localparam logic [CfgAddrW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgAddrW-1:0] RegSpare3 = 2'd3;

  typedef enum int {FILL_CLEAR, FILL_SOLID, FILL_SPARSE, FILL_RECT, FILL_NOISE} fill_t;

  // tracks the image in flight and holds the boxes still owed by the block
  class bbox_tracker;
    logic [WidthW-1:0] width_reg;
    logic [7:0]        transp_reg;
    logic [7:0]        col;
    logic [8:0]        row;
    logic [CoordW-1:0] lc, lr, gc, gr;
    logic              seen, ovf;
    logic [CountW-1:0] count;
    result_t           boxes_due[$];
    int                errors;

    function new();
      width_reg  = 9'd256;
      transp_reg = 8'd0;
      errors     = 0;
      clear_image();
    endfunction

    function void clear_image();
      col   = '0;
      row   = '0;
      lc    = '1;
      lr    = '1;
      gc    = '0;
      gr    = '0;
      seen  = 1'b0;
      ovf   = 1'b0;
      count = '0;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
      if (addr == REG_IMAGE_WIDTH) width_reg = data;
      else if (addr == REG_TRANSPARENT_INDEX) transp_reg = data[7:0];
    endfunction

    function void note_pixel(logic [7:0] pix, logic last);
      int unsigned w, bw, bh;
      result_t box;
      if (width_reg == 0) w = 1;
      else if (width_reg > CoordLimit) w = 256;
      else w = width_reg;
      if (width_reg > CoordLimit || int'(width_reg) > MaxDim) ovf = 1'b1;
      if (int'(row) >= MaxDim || row >= CoordLimit) ovf = 1'b1;
      // rows at or past 256 do not fit 8-bit coordinates and are not tracked
      if (row < CoordLimit && pix != transp_reg) begin
        if (col < lc) lc = col;
        if (col > gc) gc = col;
        if (row[7:0] < lr) lr = row[7:0];
        if (row[7:0] > gr) gr = row[7:0];
        seen  = 1'b1;
        count = count + 1'b1;
      end
      if (int'(col) + 1 >= int'(w)) begin
        col = '0;
        if (row < CoordLimit) row = row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
      if (!last) return;
      box = '0;
      box.any_opaque = seen;
      box.too_large  = ovf;
      if (seen) begin
        bw = int'(gc) - int'(lc) + 1;
        bh = int'(gr) - int'(lr) + 1;
        box.box_x   = lc;
        box.box_y   = lr;
        box.box_w   = bw[WidthW-1:0];
        box.box_h   = bh[WidthW-1:0];
        box.is_slab = (int'(count) == bw * bh);
      end
      boxes_due = {boxes_due, box};
      clear_image();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_box(logic [OutDataW-1:0] tdata, logic tuser);
      result_t want;
      if (boxes_due.size() == 0) begin
        $display("%0t: unexpected result item, expected none actual tdata=%h tuser=%b",
                 $time, tdata, tuser);
        errors++;
        return;
      end
      want = boxes_due.pop_front();
      compare_field("any_opaque", want.any_opaque, tdata[0]);
      compare_field("box_x", want.box_x, tdata[8:1]);
      compare_field("box_y", want.box_y, tdata[16:9]);
      compare_field("box_w", want.box_w, tdata[25:17]);
      compare_field("box_h", want.box_h, tdata[34:26]);
      compare_field("too_large", want.too_large, tdata[35]);
      compare_field("is_slab", want.is_slab, tuser);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_data;

  bbox_tracker sb = new();
  bit          quiet = 1'b0;
  int unsigned gap_pct = 20;
  int unsigned stall_pct = 20;
  int unsigned items_sent = 0;

  opaque_bbox_classifier #(.MAX_DIM(MaxDim)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // result receiver, stalls in short bursts
  initial begin
    int unsigned hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(99) < stall_pct) begin
        out_tready = 1'b0;
        hold = $urandom_range(3);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_box(out_tdata, out_tuser);
  end

  function automatic logic [7:0] opaque_value();
    return sb.transp_reg + 8'($urandom_range(1, 255));
  endfunction

  task automatic push_pixel(logic [7:0] pix, logic last);
    if (!quiet && $urandom_range(99) < gap_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = pix;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(pix, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_image(int unsigned npix, fill_t fill);
    int unsigned ew, rows, x0, x1, y0, y1, c, r, i;
    logic [7:0] pix;
    if (sb.width_reg == 0) ew = 1;
    else if (sb.width_reg > CoordLimit) ew = 256;
    else ew = sb.width_reg;
    rows = (npix + ew - 1) / ew;
    x0 = $urandom_range(ew - 1);
    x1 = $urandom_range(ew - 1, x0);
    y0 = $urandom_range(rows - 1);
    y1 = $urandom_range(rows - 1, y0);
    for (i = 0; i < npix; i++) begin
      c = i % ew;
      r = i / ew;
      case (fill)
        FILL_CLEAR:  pix = sb.transp_reg;
        FILL_SOLID:  pix = opaque_value();
        FILL_SPARSE: pix = ($urandom_range(7) == 0) ? opaque_value() : sb.transp_reg;
        FILL_RECT: begin
          pix = (c >= x0 && c <= x1 && r >= y0 && r <= y1) ? opaque_value() : sb.transp_reg;
        end
        default:     pix = 8'($urandom_range(255));
      endcase
      push_pixel(pix, i == npix - 1);
    end
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    cfg_valid = 1'b1;
    cfg_addr  = addr;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(addr, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    while (sb.boxes_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    int unsigned phase_width [14] = '{3, 1, 0, 256, 16, 511, 2, 300, 7, 257, 13, 255, 4, 9};
    int unsigned p, phase_end, ew, npix, roll;
    fill_t fill;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr  = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: 256 wide, index 0 transparent
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hff, 1'b0);
    push_pixel(8'h01, 1'b0);
    push_pixel(8'h80, 1'b1);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h05, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h07, 1'b1);
    drain();
    // zero width acts as one pixel per row
    write_reg(REG_IMAGE_WIDTH, 9'd0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h09, 1'b0);
    push_pixel(8'h09, 1'b0);
    push_pixel(8'h00, 1'b1);
    drain();
    write_reg(REG_TRANSPARENT_INDEX, 9'h1ff);
    push_pixel(8'hff, 1'b0);
    push_pixel(8'h00, 1'b1);
    drain();
    // width past the coordinate range
    write_reg(REG_IMAGE_WIDTH, 9'd511);
    push_pixel(8'h03, 1'b1);
    drain();
    // unused indexes must leave both registers alone
    write_reg(RegSpare2, 9'h1ff);
    write_reg(RegSpare3, 9'h000);
    push_pixel(8'hfe, 1'b0);
    push_pixel(8'hff, 1'b1);

    for (p = 0; p < 14; p++) begin
      drain();
      quiet     = (p >= 12);
      gap_pct   = $urandom_range(2) * 15;
      stall_pct = $urandom_range(2) * 15;
      write_reg(REG_IMAGE_WIDTH, 9'(phase_width[p]));
      case (p % 3)
        0:       write_reg(REG_TRANSPARENT_INDEX, {1'($urandom_range(1)), 8'h00});
        1:       write_reg(REG_TRANSPARENT_INDEX, {1'($urandom_range(1)), 8'hff});
        default: write_reg(REG_TRANSPARENT_INDEX, 9'($urandom_range(511)));
      endcase
      if ($urandom_range(2) == 0) write_reg(RegSpare2 + 2'($urandom_range(1)),
                                            9'($urandom_range(511)));
      // tall and wide images reach row 255, column 255 and the overflow limit
      if (phase_width[p] == 1 || phase_width[p] == 256)
        send_image($urandom_range(256, 262), $urandom_range(1) ? FILL_SOLID : FILL_RECT);
      ew = (phase_width[p] == 0) ? 1 : (phase_width[p] > 256) ? 256 : phase_width[p];
      phase_end = items_sent + 15;
      while (items_sent < phase_end) begin
        npix = (ew <= 16) ? $urandom_range(1, (ew * 5 > 40) ? 40 : ew * 5)
                          : $urandom_range(1, 24);
        roll = $urandom_range(9);
        if (roll < 2) fill = FILL_CLEAR;
        else if (roll < 4) fill = FILL_SOLID;
        else if (roll < 6) fill = FILL_SPARSE;
        else if (roll < 9) fill = FILL_RECT;
        else fill = FILL_NOISE;
        send_image(npix, fill);
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/obc_pkg.sv
src/obc_tracker.sv
src/obc_box.sv
src/opaque_bbox_classifier.sv
tb/tb.sv
